@@ rtl/bis_pkg.sv @@
// Shared types, widths, codes and defaults of the bilinear image scaler.
package bis_pkg;

	localparam int PIX_W       = 8;
	localparam int COORD_W     = 12;
	localparam int SRC_SZ_W    = 9;
	localparam int DST_SZ_W    = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam int DEF_MAX_SRC_HEIGHT = 256;
	localparam int DEF_MAX_SRC_WIDTH  = 256;
	localparam int DEF_FRAC_BITS      = 8;

	localparam logic [SRC_SZ_W-1:0] RST_SRC_SIZE = SRC_SZ_W'(256);
	localparam logic [DST_SZ_W-1:0] RST_DST_SIZE = DST_SZ_W'(256);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd3;

	// item opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic               op;
		logic [PIX_W-1:0]   pixel_in;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             coord_error;
	} result_t;

endpackage

@@ rtl/bis_ram.sv @@
// Generic single-port RAM with registered read data.
module bis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/bis_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module bis_div #(
	parameter int DIVIDEND_W = 29,
	parameter int DIVISOR_W  = 13,
	parameter int QUO_W      = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [QUO_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W:0]   trial;

	// upper dividend bits stay below the divisor, so only QUO_W steps are needed
	assign trial    = {rem_q, quo_q[QUO_W-1]} - {1'b0, divisor};
	assign done     = (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (!done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIVISOR_W'(dividend >> QUO_W);
			quo_q <= dividend[QUO_W-1:0];
		end else if (!done) begin
			if (!trial[DIVISOR_W]) begin
				rem_q <= trial[DIVISOR_W-1:0];
			end else begin
				rem_q <= {rem_q[DIVISOR_W-2:0], quo_q[QUO_W-1]};
			end
			quo_q <= {quo_q[QUO_W-2:0], ~trial[DIVISOR_W]};
		end
	end

endmodule

@@ rtl/bilinear_image_scaler.sv @@
// Top level of the bilinear image scaler: sequencer, image store and blend datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  item     | item_valid / item_stall   | item   (op, pixel_in, out_row, out_col)
//  result   | result_valid / result_stall | result (pixel_out, coord_error)
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A load request is accepted, then written to the store, and gives no result.
//  A compute request reads four neighbors inside the image and one on the bottom or
//  right border; the shared divider (one quotient bit per cycle, row then column) and
//  the single-port image store (one neighbor read at a time) set how long it takes.
//  A request outside the destination skips the divider and the store. The store needs
//  no clearing pass after reset. A finished result waits in the output register while
//  result_stall is high; the sequencer holds in its last step until that register
//  frees up.
module bilinear_image_scaler #(
	parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
	parameter int FRAC_BITS      = bis_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  bis_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bis_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH   = MAX_SRC_HEIGHT * MAX_SRC_WIDTH;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SZ_W    = bis_pkg::SRC_SZ_W;
	localparam int Q_W     = SZ_W + FRAC_BITS;
	localparam int PROD_W  = bis_pkg::COORD_W + SZ_W;
	localparam int DIVD_W  = PROD_W + FRAC_BITS;
	localparam int BASE_W  = 2 * SZ_W;
	localparam int WT_W    = FRAC_BITS + 1;
	localparam int W_W     = 2 * FRAC_BITS + 1;
	localparam int ACC_W   = 2 * FRAC_BITS + bis_pkg::PIX_W;
	localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_BITS;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOAD = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_DIV  = 8'b0000_1000,
		S_ADDR = 8'b0001_0000,
		S_RD   = 8'b0010_0000,
		S_MAC  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SZ_W-1:0]              src_height_q;
	logic [SZ_W-1:0]              src_width_q;
	logic [bis_pkg::DST_SZ_W-1:0] dst_height_q;
	logic [bis_pkg::DST_SZ_W-1:0] dst_width_q;
	logic [SZ_W-1:0]              sh;
	logic [SZ_W-1:0]              sw;
	logic [ADDR_W:0]              total_q;

	// request and working registers
	bis_pkg::item_t   item_q;
	logic             axis_q;
	logic             err_q;
	logic [Q_W-1:0]   pr_q;
	logic [Q_W-1:0]   pc_q;
	logic [ADDR_W-1:0] base_q;
	logic [FRAC_BITS-1:0] u_q;
	logic [FRAC_BITS-1:0] v_q;
	logic             border_q;
	logic [1:0]       nb_q;
	logic [W_W-1:0]   w_q;
	logic [ACC_W-1:0] acc_q;
	logic [ADDR_W-1:0] pos_q;

	bis_pkg::result_t result_q;
	logic             result_valid_q;

	logic                          accept;
	logic                          out_free;
	logic [bis_pkg::COORD_W-1:0]   coord;
	logic [SZ_W-1:0]               size;
	logic [PROD_W-1:0]             prod;
	logic                          div_done;
	logic [Q_W-1:0]                quo;
	logic [SZ_W-1:0]               ri_raw;
	logic [SZ_W-1:0]               ci_raw;
	logic [SZ_W-1:0]               ri;
	logic [SZ_W-1:0]               ci;
	logic [WT_W-1:0]               wa;
	logic [WT_W-1:0]               wb;
	logic [ADDR_W:0]               pos_eff;
	logic [ADDR_W:0]               pos_nx;
	logic [ADDR_W-1:0]             rd_addr;
	logic [ADDR_W-1:0]             ram_addr;
	logic [bis_pkg::PIX_W-1:0]     ram_rdata;
	logic                          ram_we;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// clamp source sizes to 1..MAX
	always_comb begin
		if (src_height_q == '0) begin
			sh = SZ_W'(1);
		end else if (32'(src_height_q) > 32'(MAX_SRC_HEIGHT)) begin
			sh = SZ_W'(MAX_SRC_HEIGHT);
		end else begin
			sh = src_height_q;
		end
		if (src_width_q == '0) begin
			sw = SZ_W'(1);
		end else if (32'(src_width_q) > 32'(MAX_SRC_WIDTH)) begin
			sw = SZ_W'(MAX_SRC_WIDTH);
		end else begin
			sw = src_width_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_height_q <= bis_pkg::RST_SRC_SIZE;
			src_width_q  <= bis_pkg::RST_SRC_SIZE;
			dst_height_q <= bis_pkg::RST_DST_SIZE;
			dst_width_q  <= bis_pkg::RST_DST_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bis_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[SZ_W-1:0];
				bis_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[SZ_W-1:0];
				bis_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				bis_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pixel count of the source image, registered from the clamped size registers
	always_ff @(posedge clk) begin
		total_q <= (ADDR_W+1)'(BASE_W'(sh) * BASE_W'(sw));
	end

	// shared divider: row axis first, then column axis
	assign coord = axis_q ? item_q.out_col : item_q.out_row;
	assign size  = axis_q ? sw : sh;
	assign prod  = PROD_W'(coord) * PROD_W'(size);

	bis_div #(
		.DIVIDEND_W (DIVD_W),
		.DIVISOR_W  (bis_pkg::DST_SZ_W),
		.QUO_W      (Q_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_MUL),
		.dividend ({prod, {FRAC_BITS{1'b0}}}),
		.divisor  (axis_q ? dst_width_q : dst_height_q),
		.done     (div_done),
		.quotient (quo)
	);

	// integer source position, clamped into the image
	assign ri_raw = pr_q[Q_W-1:FRAC_BITS];
	assign ci_raw = pc_q[Q_W-1:FRAC_BITS];
	assign ri     = (ri_raw >= sh) ? sh - 1'b1 : ri_raw;
	assign ci     = (ci_raw >= sw) ? sw - 1'b1 : ci_raw;

	// neighbor weights; on the border the single neighbor gets full weight
	always_comb begin
		if (border_q) begin
			wa = ONE;
			wb = ONE;
		end else begin
			wa = nb_q[1] ? WT_W'(u_q) : ONE - WT_W'(u_q);
			wb = nb_q[0] ? WT_W'(v_q) : ONE - WT_W'(v_q);
		end
	end

	// neighbor order: top-left, top-right, bottom-left, bottom-right
	assign rd_addr = base_q + (nb_q[1] ? ADDR_W'(sw) : '0) + ADDR_W'(nb_q[0]);

	// load position: restart when outside the current image, wrap after the last pixel
	assign pos_eff = ((ADDR_W+1)'(pos_q) >= total_q) ? '0 : (ADDR_W+1)'(pos_q);
	assign pos_nx  = pos_eff + 1'b1;

	assign ram_we   = (state_q == S_LOAD);
	assign ram_addr = ram_we ? pos_eff[ADDR_W-1:0] : rd_addr;

	bis_ram #(
		.WIDTH (bis_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (item_q.pixel_in),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pos_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// raise the result as the sequencer finishes, drop it once the receiver takes it
			if (state_q == S_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.op == bis_pkg::OP_LOAD) begin
							state_q <= S_LOAD;
						end else if (item.out_row >= dst_height_q ||
								item.out_col >= dst_width_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_LOAD: begin
					pos_q   <= (pos_nx >= total_q) ? '0 : pos_nx[ADDR_W-1:0];
					state_q <= S_IDLE;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= axis_q ? S_ADDR : S_MUL;
					end
				end
				S_ADDR: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_MAC;
				end
				S_MAC: begin
					state_q <= (border_q || nb_q == 2'd3) ? S_DONE : S_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= item;
					axis_q <= 1'b0;
					err_q  <= (item.out_row >= dst_height_q) || (item.out_col >= dst_width_q);
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (axis_q) begin
						pc_q <= quo;
					end else begin
						pr_q   <= quo;
						axis_q <= 1'b1;
					end
				end
			end
			S_ADDR: begin
				base_q   <= ADDR_W'(BASE_W'(ri) * BASE_W'(sw) + BASE_W'(ci));
				u_q      <= pr_q[FRAC_BITS-1:0];
				v_q      <= pc_q[FRAC_BITS-1:0];
				border_q <= ((SZ_W+1)'(ri) + 1'b1 >= (SZ_W+1)'(sh)) ||
					((SZ_W+1)'(ci) + 1'b1 >= (SZ_W+1)'(sw));
				nb_q     <= 2'd0;
				acc_q    <= '0;
			end
			S_RD: begin
				w_q <= W_W'(W_W'(wa) * W_W'(wb));
			end
			S_MAC: begin
				acc_q <= acc_q + ACC_W'(ACC_W'(w_q) * ACC_W'(ram_rdata));
				nb_q  <= nb_q + 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					result_q.coord_error <= err_q;
					result_q.pixel_out   <= err_q ? '0 :
						acc_q[2*FRAC_BITS +: bis_pkg::PIX_W];
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the bilinear image scaler: directed and random requests, checked per result.
module testbench;

	localparam int FRAC       = bis_pkg::DEF_FRAC_BITS;
	localparam int MAX_H      = bis_pkg::DEF_MAX_SRC_HEIGHT;
	localparam int MAX_W      = bis_pkg::DEF_MAX_SRC_WIDTH;
	localparam int PIX_W      = bis_pkg::PIX_W;
	localparam int COORD_W    = bis_pkg::COORD_W;
	localparam int SRC_SZ_W   = bis_pkg::SRC_SZ_W;
	localparam int DST_SZ_W   = bis_pkg::DST_SZ_W;
	localparam int CFG_IDX_W  = bis_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = bis_pkg::CFG_DATA_W;
	localparam int SETTLE    = 16;       // lets a trailing load finish after its acceptance
	localparam int DRAIN     = 2 * 49;   // longest compute at FRAC_BITS = 8, twice
	localparam int HOLD_LEN  = 400;      // long result hold-off, in cycles
	localparam int ITEM_GOAL = 850;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	bis_pkg::item_t        item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	bis_pkg::result_t      result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = bis_pkg::REG_SRC_HEIGHT;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	bilinear_image_scaler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow of the block: image store, load pointer and the four size registers.
	logic [PIX_W-1:0]    src_img [0:MAX_H*MAX_W-1];
	int unsigned         load_ptr  = 0;
	logic [SRC_SZ_W-1:0] cur_src_h = bis_pkg::RST_SRC_SIZE;
	logic [SRC_SZ_W-1:0] cur_src_w = bis_pkg::RST_SRC_SIZE;
	logic [DST_SZ_W-1:0] cur_dst_h = bis_pkg::RST_DST_SIZE;
	logic [DST_SZ_W-1:0] cur_dst_w = bis_pkg::RST_DST_SIZE;

	bis_pkg::item_t   pend_q[$];      // requests waiting for the driver
	bis_pkg::result_t pixel_due[$];   // predicted pixels, oldest first
	int          items_taken  = 0;
	int          results_seen = 0;
	int          fails        = 0;
	int          holds_done   = 0;
	int          hold_left    = 0;
	int          queued       = 0;
	int unsigned filled       = 0;   // store entries 0..filled-1 are known written
	logic        item_taken   = 1'b0;
	logic        calm;

	// Window with no idling on either side.
	assign calm = (items_taken >= 300) && (items_taken < 450);

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// Apply one accepted request to the shadow; a compute request yields one expected pixel.
	task automatic take_item(input bis_pkg::item_t it);
		int unsigned      sh, sw, total, ri, ci, base;
		longint unsigned  pr, pc, u, v, acc, one;
		bis_pkg::result_t res;
		sh    = clamp_dim(cur_src_h, MAX_H);
		sw    = clamp_dim(cur_src_w, MAX_W);
		total = sh * sw;
		one   = 64'd1 << FRAC;
		res   = '0;
		if (it.op == bis_pkg::OP_LOAD) begin
			// restart when a size change left the pointer outside the image
			if (load_ptr >= total) load_ptr = 0;
			src_img[load_ptr] = it.pixel_in;
			load_ptr++;
			if (load_ptr >= total) load_ptr = 0;
		end else begin
			if (it.out_row >= cur_dst_h || it.out_col >= cur_dst_w) begin
				res.coord_error = 1'b1;
			end else begin
				pr = ((64'(it.out_row) * sh) << FRAC) / cur_dst_h;
				pc = ((64'(it.out_col) * sw) << FRAC) / cur_dst_w;
				ri = 32'(pr >> FRAC);
				ci = 32'(pc >> FRAC);
				u  = pr & (one - 1);
				v  = pc & (one - 1);
				if (ri >= sh) ri = sh - 1;
				if (ci >= sw) ci = sw - 1;
				base = ri * sw + ci;
				if (ri + 1 >= sh || ci + 1 >= sw) begin
					// bottom or right border: top-left neighbor, unblended
					res.pixel_out = src_img[base];
				end else begin
					acc = (one - u) * (one - v) * src_img[base]
					    + (one - u) * v * src_img[base + 1]
					    + u * (one - v) * src_img[base + sw]
					    + u * v * src_img[base + sw + 1];
					res.pixel_out = PIX_W'(acc >> (2 * FRAC));
				end
			end
			pixel_due.push_back(res);
		end
	endtask

	task automatic queue_load(input logic [PIX_W-1:0] pix);
		bis_pkg::item_t it;
		it.op       = bis_pkg::OP_LOAD;
		it.pixel_in = pix;
		it.out_row  = COORD_W'($urandom_range(4095, 0));   // unused by a load, toggled anyway
		it.out_col  = COORD_W'($urandom_range(4095, 0));
		pend_q.push_back(it);
		queued++;
	endtask

	task automatic queue_compute(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
		bis_pkg::item_t it;
		it.op       = bis_pkg::OP_COMPUTE;
		it.pixel_in = PIX_W'($urandom_range(255, 0));    // unused by a compute, toggled anyway
		it.out_row  = r;
		it.out_col  = c;
		pend_q.push_back(it);
		queued++;
	endtask

	// Mostly inside the destination, some right at its edge, some anywhere.
	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim);
		int p;
		p = $urandom_range(99, 0);
		if (lim == 0 || p >= 88) return COORD_W'($urandom_range(4095, 0));
		if (p >= 78) return COORD_W'(lim - 1 + $urandom_range(1, 0));
		return COORD_W'($urandom_range(lim - 1, 0));
	endfunction

	task automatic mixed_run(input int n, input int load_pct);
		int unsigned rl, cl;
		rl = (cur_dst_h > 4096) ? 4096 : cur_dst_h;
		cl = (cur_dst_w > 4096) ? 4096 : cur_dst_w;
		repeat (n) begin
			if ($urandom_range(99, 0) < load_pct) queue_load(PIX_W'($urandom_range(255, 0)));
			else queue_compute(pick_coord(rl), pick_coord(cl));
		end
	endtask

	// Load a whole source image when asked to, or when the current size reads past the written entries.
	task automatic cover_source(input bit full);
		int unsigned total;
		total = clamp_dim(cur_src_h, MAX_H) * clamp_dim(cur_src_w, MAX_W);
		if (full || total > filled) begin
			for (int k = 0; k < total; k++) begin
				if (k % 4 == 0) queue_load(8'h00);
				else if (k % 4 == 1) queue_load(8'hFF);
				else queue_load(PIX_W'($urandom_range(255, 0)));
			end
			if (total > filled) filled = total;
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bis_pkg::REG_SRC_HEIGHT: cur_src_h = val[SRC_SZ_W-1:0];
			bis_pkg::REG_SRC_WIDTH:  cur_src_w = val[SRC_SZ_W-1:0];
			bis_pkg::REG_DST_HEIGHT: cur_dst_h = val[DST_SZ_W-1:0];
			bis_pkg::REG_DST_WIDTH:  cur_dst_w = val[DST_SZ_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] sw,
	                         input logic [CFG_DATA_W-1:0] dh, input logic [CFG_DATA_W-1:0] dw);
		set_reg(bis_pkg::REG_SRC_HEIGHT, sh);
		set_reg(bis_pkg::REG_SRC_WIDTH, sw);
		set_reg(bis_pkg::REG_DST_HEIGHT, dh);
		set_reg(bis_pkg::REG_DST_WIDTH, dw);
	endtask

	// Wait until every request is in and every pixel is out, then let a trailing load finish.
	task automatic wait_idle();
		while (pend_q.size() != 0 || item_valid || pixel_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Request driver: hold an offered request until accepted, then advance or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (pend_q.size() != 0 && (calm || $urandom_range(99, 0) >= 11)) begin
				item_valid <= 1'b1;
				item       <= pend_q.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus two long hold-offs while requests keep coming
	// so the output register fills and the block stalls its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (holds_done < 2 && results_seen >= 30 + 200 * holds_done
		             && pend_q.size() > 4) begin
			result_stall <= 1'b1;
			hold_left    <= HOLD_LEN;
			holds_done   <= holds_done + 1;
		end else begin
			result_stall <= !calm && ($urandom_range(99, 0) < 11);
		end
	end

	// Monitor: check each accepted pixel against the oldest prediction, then
	// predict for the request accepted on this edge.
	always @(posedge clk) begin : monitor_p
		bis_pkg::result_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (pixel_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected pixel: pixel_out=%0d coord_error=%0b",
						         $realtime, result.pixel_out, result.coord_error);
				end else begin
					want = pixel_due.pop_front();
					if (result.pixel_out !== want.pixel_out
					    || result.coord_error !== want.coord_error) begin
						fails++;
						if (fails <= 10)
							$display("%0t: pixel mismatch: pixel_out=%0d (want %0d) %s%0b (want %0b)",
							         $realtime, result.pixel_out, want.pixel_out,
							         "coord_error=", result.coord_error, want.coord_error);
					end
				end
			end
			if (item_valid && !item_stall) begin
				take_item(item);
				items_taken <= items_taken + 1;
			end
		end
	end

	initial begin
		int unsigned sh, sw, dh, dw;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset sizes: only coordinates outside the 256x256 destination, nothing loaded yet.
		queue_compute(12'd256, 12'd0);
		queue_compute(12'd0, 12'd256);
		queue_compute(12'd4095, 12'd4095);
		wait_idle();

		// 3x4 source to 7x9; upper data bits of a source size are dropped.
		configure(13'h1E03, 13'd4, 13'd7, 13'd9);
		cover_source(1'b0);
		queue_compute(12'd0, 12'd0);     // exact source pixel, zero fractions
		queue_compute(12'd3, 12'd4);     // interior blend
		queue_compute(12'd4, 12'd2);     // interior blend, other fractions
		queue_compute(12'd6, 12'd8);     // bottom-right corner
		queue_compute(12'd2, 12'd8);     // right border
		queue_compute(12'd6, 12'd3);     // bottom border
		queue_compute(12'd7, 12'd0);     // row just outside
		queue_compute(12'd0, 12'd9);     // column just outside
		repeat (5) queue_load(PIX_W'($urandom_range(255, 0)));
		wait_idle();

		// Shrink the source while the load pointer sits past it: the next load restarts at zero.
		configure(13'd2, 13'd2, 13'd5, 13'd5);
		queue_load(8'hA5);
		queue_compute(12'd1, 12'd1);
		queue_compute(12'd4, 12'd4);
		queue_compute(12'd2, 12'd3);
		queue_compute(12'd5, 12'd0);
		wait_idle();

		// Tallest source, tallest destination.
		configure(13'd256, 13'd1, 13'd4096, 13'd3);
		cover_source(1'b0);
		mixed_run(20, 0);
		wait_idle();

		// Source sizes out of range clamp to 1 and 256; widest destination field value.
		configure(13'd0, 13'd511, 13'd1, 13'd8191);
		cover_source(1'b0);
		mixed_run(14, 10);
		wait_idle();

		// Zero destination flags every coordinate.
		configure(13'd5, 13'd5, 13'd0, 13'd0);
		mixed_run(6, 0);
		wait_idle();

		// Single-pixel source and destination.
		configure(13'd1, 13'd1, 13'd1, 13'd1);
		cover_source(1'b0);
		queue_compute(12'd0, 12'd0);
		queue_compute(12'd0, 12'd1);
		queue_compute(12'd1, 12'd0);
		wait_idle();

		// Random phases: small sources, mixed destination sizes, loads interleaved.
		while (queued < ITEM_GOAL) begin
			sh = $urandom_range(10, 1);
			sw = $urandom_range(10, 1);
			if ($urandom_range(3, 0) == 0) begin
				sh = $urandom_range(16, 1);
				sw = $urandom_range(16, 1);
			end
			case ($urandom_range(7, 0))
				0:       dh = 1;
				1:       dh = 4096;
				2:       dh = $urandom_range(4096, 1);
				default: dh = $urandom_range(24, 1);
			endcase
			case ($urandom_range(7, 0))
				0:       dw = 1;
				1:       dw = 4096;
				2:       dw = $urandom_range(4096, 1);
				default: dw = $urandom_range(24, 1);
			endcase
			configure(CFG_DATA_W'(sh), CFG_DATA_W'(sw), CFG_DATA_W'(dh), CFG_DATA_W'(dw));
			cover_source($urandom_range(2, 0) == 0 && sh * sw <= 64);
			mixed_run($urandom_range(35, 15), 30);
			wait_idle();
		end

		repeat (DRAIN) @(posedge clk);
		if (fails == 0 && pixel_due.size() == 0) begin
			$display("PASS bilinear_image_scaler");
		end else begin
			$display("FAIL bilinear_image_scaler");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAIL bilinear_image_scaler");
		$finish;
	end

endmodule
